// ===== rtl/core/bb3_pkg.sv =====
package bb3_pkg;

    localparam int DEF_MAX_WIDTH = 1024;

    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int ROW_W      = FH_W + 1;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PX_W       = CH_W * NUM_CH;
    localparam int SUM_W      = 12;
    localparam int CNT_W      = 4;
    localparam int DIVX_W     = SUM_W + 1;
    localparam int RCP_SH     = 19;
    localparam int RCP_W      = 19;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

    // position flags of the result centered on one input beat
    typedef struct packed {
        logic             res;
        logic             top_ok;
        logic             bot_ok;
        logic             left_ok;
        logic             right_ok;
        logic             eor;
        logic             eof;
        logic [CNT_W-1:0] count;
    } t_pos;

    // ceil(2^RCP_SH / (2*n)) for the neighbor counts that can occur
    function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RCP_W-1:0] r;
        case (n)
            CNT_W'(1): r = RCP_W'(262144);
            CNT_W'(2): r = RCP_W'(131072);
            CNT_W'(3): r = RCP_W'(87382);
            CNT_W'(4): r = RCP_W'(65536);
            CNT_W'(6): r = RCP_W'(43691);
            CNT_W'(9): r = RCP_W'(29128);
            default:   r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/box_blur_3x3_edge_aware.sv =====
// 3x3 box blur of an RGB raster stream, counting only neighbors inside the frame.
// Input beats on s_axis: tuser=1 marks a drain tick, tdata carries the pixel.
// Results on m_axis: tdata is the rounded average, tlast ends a row, tuser ends the frame.
// Register writes on the cfg channel (frame_width, frame_height) restart the frame
// and must be issued only while the pipeline is empty; o_cfg_ready is always high.
// Throughput: one beat per cycle while m_axis accepts; the line memory that holds the two rows above the
// input row takes one read and one write-back each cycle, the window and adders keep pace.
// A result reaches m_axis through the stage-1, stage-2 and output registers after the beat
// that completes its neighborhood, which is one row plus one pixel after its own pixel.
// After the last pixel of a frame send frame_width+1 drain ticks to flush it.
// Beats that produce no result (first row, drains past the frame) leave bubbles
// that let new input in while a finished result waits on a stalled m_axis.
// When m_axis stalls the stages fill up and s_axis_tready drops.
// Reset clears the counters and valid flags and restores default width and
// height; the line memory needs no clearing, since stale entries are never counted.
module box_blur_3x3_edge_aware
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PX_W-1:0]       s_axis_tdata,   // [7:0] in_red, [15:8] in_green, [23:16] in_blue
    input  logic                  s_axis_tuser,   // [0] req_type

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PX_W-1:0]       m_axis_tdata,   // [7:0] out_red, [15:8] out_green, [23:16] out_blue
    output logic                  m_axis_tlast,   // end_of_row
    output logic                  m_axis_tuser,   // [0] end_of_frame

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > FW_W) ? WW : FW_W;

    // configuration
    logic [FW_W-1:0]  r_frame_width;
    logic [FH_W-1:0]  r_frame_height;
    logic             cfg_fire;
    logic             cfg_restart;
    logic [EW-1:0]    fw_ext;
    logic [WW-1:0]    w_eff;
    logic [FH_W-1:0]  h_eff;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    // only a write to a known register restarts the frame
    assign cfg_restart = cfg_fire && ((i_cfg_index == REG_FRAME_WIDTH) ||
                                      (i_cfg_index == REG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (cfg_fire) begin
            if (i_cfg_index == REG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_data[FW_W-1:0];
            end
            if (i_cfg_index == REG_FRAME_HEIGHT) begin
                r_frame_height <= i_cfg_data[FH_W-1:0];
            end
        end
    end

    assign fw_ext = EW'(r_frame_width);

    always_comb begin
        if (fw_ext == '0) begin
            w_eff = WW'(1);
        end else if (fw_ext > EW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(fw_ext);
        end
        h_eff = (r_frame_height == '0) ? FH_W'(1) : r_frame_height;
    end

    // handshake and stage advance
    logic adv_out, adv2, adv1;
    logic s_fire, s1_fire, s2_fire;
    logic r_s1_valid, r_s2_valid, r_out_valid;

    assign adv_out       = !r_out_valid || m_axis_tready;
    assign adv2          = !r_s2_valid || adv_out;
    assign adv1          = !r_s1_valid || adv2;
    assign s_axis_tready = adv1 && i_rst_n;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign s1_fire       = r_s1_valid && adv2;
    assign s2_fire       = r_s2_valid && adv_out;

    // input position and result geometry
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    c;
    logic             c_is0;
    logic             c_wrap;
    logic [ROW_W-1:0] rr;
    logic [ROW_W-1:0] h_row;
    logic [1:0]       n_rows, n_cols;
    logic [PX_W-1:0]  s0_px;
    t_pos             s0_pos;

    always_comb begin
        c      = (WW'(r_col) >= w_eff) ? '0 : r_col;
        c_is0  = (c == '0);
        c_wrap = (WW'(c) + WW'(1)) >= w_eff;
        // result row is one above the input row, two when the column wraps
        rr     = c_is0 ? (r_row - ROW_W'(1)) : r_row;
        h_row  = ROW_W'(h_eff);

        s0_pos.res      = (rr != '0) && (rr <= h_row);
        s0_pos.top_ok   = (rr >= ROW_W'(2));
        s0_pos.bot_ok   = (rr != h_row);
        s0_pos.left_ok  = c_is0 ? (w_eff >= WW'(2)) : (WW'(c) >= WW'(2));
        s0_pos.right_ok = !c_is0;
        s0_pos.eor      = c_is0;
        s0_pos.eof      = c_is0 && (rr == h_row);
        n_rows          = 2'd1 + {1'b0, s0_pos.top_ok} + {1'b0, s0_pos.bot_ok};
        n_cols          = 2'd1 + {1'b0, s0_pos.left_ok} + {1'b0, s0_pos.right_ok};
        s0_pos.count    = CNT_W'(n_rows) * CNT_W'(n_cols);

        s0_px = s_axis_tuser ? '0 : s_axis_tdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (s_fire) begin
            if (s0_pos.eof) begin
                r_col <= '0;
                r_row <= '0;
            end else if (c_wrap) begin
                r_col <= '0;
                r_row <= r_row + ROW_W'(1);
            end else begin
                r_col <= c + CW'(1);
            end
        end
    end

    // line memory: each entry holds {row two above, row above} for one column
    logic [2*PX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PX_W-1:0] r_mem_q;
    logic [2*PX_W-1:0] r_byp_data;
    logic              r_byp;
    logic [2*PX_W-1:0] q_eff;
    logic [2*PX_W-1:0] wr_data;
    logic [PX_W-1:0]   up_px, mid_px;

    logic [CW-1:0]     r_s1_addr;
    logic [PX_W-1:0]   r_s1_px;
    t_pos              r_s1_pos;

    assign q_eff   = r_byp ? r_byp_data : r_mem_q;
    assign up_px   = q_eff[2*PX_W-1:PX_W];
    assign mid_px  = q_eff[PX_W-1:0];
    assign wr_data = {mid_px, r_s1_px};

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            line_mem[r_s1_addr] <= wr_data;
        end
        if (s_fire) begin
            r_mem_q <= line_mem[c];
        end
    end

    // forward the write-back that collides with a read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (s_fire) begin
            r_byp <= s1_fire && (r_s1_addr == c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_byp_data <= wr_data;
            r_s1_addr  <= c;
            r_s1_px    <= s0_px;
            r_s1_pos   <= s0_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // 3x3 window, rows top to bottom, columns left to right
    logic [PX_W-1:0]  r_win   [3][3];
    logic [PX_W-1:0]  nwin    [3][3];
    logic [PX_W-1:0]  new_col [3];
    logic [2:0]       row_ok, col_ok;
    logic [SUM_W-1:0] sum     [NUM_CH];

    assign new_col[0] = up_px;
    assign new_col[1] = mid_px;
    assign new_col[2] = r_s1_px;
    assign row_ok     = {r_s1_pos.bot_ok, 1'b1, r_s1_pos.top_ok};
    assign col_ok     = {r_s1_pos.right_ok, 1'b1, r_s1_pos.left_ok};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            nwin[k][0] = r_win[k][1];
            nwin[k][1] = r_win[k][2];
            nwin[k][2] = new_col[k];
        end
        for (int ch = 0; ch < NUM_CH; ch++) begin
            sum[ch] = '0;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    if (row_ok[k] && col_ok[j]) begin
                        sum[ch] = sum[ch] + SUM_W'(nwin[k][j][ch*CH_W +: CH_W]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= nwin[k][j];
                end
            end
        end
    end

    // sums and neighbor count
    logic [SUM_W-1:0] r_s2_sum [NUM_CH];
    logic [CNT_W-1:0] r_s2_count;
    logic             r_s2_eor, r_s2_eof;

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_s2_sum[ch] <= sum[ch];
            end
            r_s2_count <= r_s1_pos.count;
            r_s2_eor   <= r_s1_pos.eor;
            r_s2_eof   <= r_s1_pos.eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_fire) begin
            r_s2_valid <= r_s1_pos.res;
        end else if (s2_fire) begin
            r_s2_valid <= 1'b0;
        end
    end

    // rounded average: floor((2*sum + n) / (2*n)) by reciprocal multiply
    logic [DIVX_W-1:0]        divx [NUM_CH];
    logic [DIVX_W+RCP_W-1:0]  prod [NUM_CH];
    logic [RCP_W-1:0]         rcp;
    logic [PX_W-1:0]          avg;
    logic [PX_W-1:0]          r_out_data;
    logic                     r_out_eor, r_out_eof;

    assign rcp = recip(r_s2_count);

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            divx[ch] = {r_s2_sum[ch], 1'b0} + DIVX_W'(r_s2_count);
            prod[ch] = (DIVX_W+RCP_W)'(divx[ch]) * (DIVX_W+RCP_W)'(rcp);
            avg[ch*CH_W +: CH_W] = prod[ch][RCP_SH +: CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_out_data <= avg;
            r_out_eor  <= r_s2_eor;
            r_out_eof  <= r_s2_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_eor;
    assign m_axis_tuser  = r_out_eof;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (r_s2_count != '0 && r_s2_count <= CNT_W'(9)))
        else $error("neighbor count out of range");

    a_eof_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && s0_pos.eof && !cfg_fire) |=> (r_col == '0 && r_row == '0))
        else $error("frame end did not restart position");

    a_eof_is_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("frame end without row end");

endmodule
